### sv/bif_pkg.sv
// Shared types, constants and the exponential table of the bilateral image filter.
package bif_pkg;

  localparam int CH_W     = 16;
  localparam int COORD_W  = 6;
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int EXP_LAST = 256;
  localparam int DIV_STEPS = CH_W;

  localparam logic [52:0] FS2     = 53'd4294836225;
  localparam logic [49:0] BIG_LIM = 50'd4294836225 << 12;

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_HALF     = 3'd2,
    REG_CHANNELS = 3'd3,
    REG_SPACE    = 3'd4,
    REG_COLOR    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              kind;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CH_W-1:0]   in_ch0;
    logic [CH_W-1:0]   in_ch1;
    logic [CH_W-1:0]   in_ch2;
    logic [CH_W-1:0]   in_ch3;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [CH_W-1:0]   out_ch0;
    logic [CH_W-1:0]   out_ch1;
    logic [CH_W-1:0]   out_ch2;
    logic [CH_W-1:0]   out_ch3;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  image_width;
    logic [6:0]  image_height;
    logic [1:0]  kernel_half;
    logic [2:0]  channel_count;
    logic [15:0] space_coeff;
    logic [15:0] color_coeff;
  } cfg_t;

  typedef struct packed {
    logic       wr;
    logic       load_req;
    logic       rd_center;
    logic       rd_nb;
    logic [2:0] ox;
    logic [2:0] oy;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

  typedef logic [16:0] exp_rom_t [0:EXP_LAST];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    t;
    logic [95:0] v;
    logic [95:0] m;
    v = 96'd1 << 32;
    for (int i = 0; i <= EXP_LAST; i++) begin
      m    = (v + 96'd32768) >> 16;
      t[i] = m[16:0];
      m    = v * 96'd4034748381 + (96'd1 << 31);
      v    = m >> 32;
    end
    return t;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

### sv/bilateral_image_filter_unit.sv
// Top level of the bilateral image filter: register port, controller and datapath.
// A filter request runs as one center read, then one window read per cycle over the
// (2*K+1)^2 window for half-size K into a weight pipeline, a drain, and a radix-2
// divide in three parallel channel lanes that share one divisor.
// One request is in work at a time; the result waits in an output register.
// Reset restores the register defaults; the pixel store is undefined until written.
module bilateral_image_filter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bif_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bif_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  bif_pkg::cfg_t       cfg_r;
  bif_pkg::ctrl_cmd_t  cmd;
  bif_pkg::dp_status_t status;
  bif_pkg::reg_idx_t   idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = bif_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= 7'd64;
      cfg_r.image_height  <= 7'd64;
      cfg_r.kernel_half   <= 2'd1;
      cfg_r.channel_count <= 3'd3;
      cfg_r.space_coeff   <= 16'd128;
      cfg_r.color_coeff   <= 16'd12800;
    end else if (wr_en) begin
      unique case (idx)
        bif_pkg::REG_WIDTH:    cfg_r.image_width   <= pwdata[6:0];
        bif_pkg::REG_HEIGHT:   cfg_r.image_height  <= pwdata[6:0];
        bif_pkg::REG_HALF:     cfg_r.kernel_half   <= pwdata[1:0];
        bif_pkg::REG_CHANNELS: cfg_r.channel_count <= pwdata[2:0];
        bif_pkg::REG_SPACE:    cfg_r.space_coeff   <= pwdata[15:0];
        bif_pkg::REG_COLOR:    cfg_r.color_coeff   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bif_pkg::REG_WIDTH:    prdata = {25'b0, cfg_r.image_width};
      bif_pkg::REG_HEIGHT:   prdata = {25'b0, cfg_r.image_height};
      bif_pkg::REG_HALF:     prdata = {30'b0, cfg_r.kernel_half};
      bif_pkg::REG_CHANNELS: prdata = {29'b0, cfg_r.channel_count};
      bif_pkg::REG_SPACE:    prdata = {16'b0, cfg_r.space_coeff};
      bif_pkg::REG_COLOR:    prdata = {16'b0, cfg_r.color_coeff};
      default:               prdata = 32'd0;
    endcase
  end

  bif_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .half      (cfg_r.kernel_half),
    .status    (status),
    .cmd       (cmd)
  );

  bif_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .in_item  (in_data),
    .status   (status),
    .out_item (out_data)
  );

endmodule

### sv/bif_ctrl.sv
// Controller state machine that sequences window reads, divide steps and result hand-off.
module bif_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_stall,
  input  logic                  out_stall,
  output logic                  out_valid,
  input  logic [1:0]            half,
  input  bif_pkg::dp_status_t   status,
  output bif_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CENTER, S_NEIGH, S_DRAIN, S_DIVI, S_DIV, S_HOLD
  } state_t;

  state_t     state_r;
  logic [2:0] ox_r;
  logic [2:0] oy_r;
  logic [3:0] cnt_r;
  logic       out_valid_r;
  logic [2:0] lim;
  logic       accept;

  assign lim      = {half, 1'b0};
  assign accept   = (state_r == S_IDLE) && in_valid;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.wr        = accept && !in_kind;
    cmd.load_req  = accept && in_kind;
    cmd.rd_center = (state_r == S_CENTER);
    cmd.rd_nb     = (state_r == S_NEIGH);
    cmd.ox        = ox_r;
    cmd.oy        = oy_r;
    cmd.div_init  = (state_r == S_DIVI);
    cmd.div_step  = (state_r == S_DIV);
    cmd.out_load  = (state_r == S_HOLD) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ox_r        <= '0;
      oy_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd.load_req) begin
            state_r <= S_CENTER;
          end
        end
        S_CENTER: begin
          ox_r    <= '0;
          oy_r    <= '0;
          state_r <= S_NEIGH;
        end
        S_NEIGH: begin
          if (ox_r == lim) begin
            ox_r <= '0;
            if (oy_r == lim) begin
              state_r <= S_DRAIN;
            end else begin
              oy_r <= oy_r + 3'd1;
            end
          end else begin
            ox_r <= ox_r + 3'd1;
          end
        end
        S_DRAIN: begin
          if (!status.pipe_busy) begin
            state_r <= S_DIVI;
          end
        end
        S_DIVI: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(bif_pkg::DIV_STEPS - 1)) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (cmd.out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/bif_dp.sv
// Datapath: pixel store, weight pipeline, accumulators, dividers and result register.
module bif_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bif_pkg::cfg_t        cfg,
  input  bif_pkg::ctrl_cmd_t   cmd,
  input  bif_pkg::in_item_t    in_item,
  output bif_pkg::dp_status_t  status,
  output bif_pkg::out_item_t   out_item
);

  logic [63:0] mem [0:bif_pkg::DEPTH-1];
  logic [63:0] rdata_r;
  logic [63:0] center_r;

  logic [5:0]  wm1, hm1;
  logic [1:0]  half;
  logic [1:0]  nch;
  logic        cc4;

  logic [5:0]  x_r, y_r, cx_r, cy_r;

  logic signed [8:0] sx, sy;
  logic [5:0]  nx, ny;
  logic [2:0]  adx, ady;
  logic [4:0]  dist2;
  logic [bif_pkg::ADDR_W-1:0] rd_addr;

  logic        v1_r, c1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic [4:0]  d2_1_r;
  logic [31:0] sq2_r [3];
  logic [15:0] val2_r [3], val3_r [3], val4_r [3], val5_r [3];
  logic [15:0] val6_r [3], val7_r [3], val8_r [3];
  logic [20:0] sp2_r, sp3_r, sp4_r, sp5_r;
  logic [49:0] p3_r;
  logic        big4_r, big5_r, zero6_r, zero7_r;
  logic [51:0] n4_r;
  logic [20:0] q14_r, q5_r;
  logic [7:0]  idx6_r;
  logic [11:0] frac6_r;
  logic [28:0] prod7_r;
  logic [16:0] hi7_r, w8_r, w9_r;
  logic [32:0] wv9_r [3];
  logic [21:0] sum_w_r;
  logic [38:0] acc_r [3];
  logic [21:0] rem_r [3];
  logic [15:0] low_r [3];

  logic [15:0] dd [3];
  logic [33:0] dsum;
  logic [51:0] nn;
  logic [19:0] aa;
  logic [36:0] ac;
  logic [52:0] s4;
  logic [52:0] q1fs, r5;
  logic [29:0] arg;
  logic [16:0] hi, lo, diff;
  logic [29:0] rnd;
  logic [39:0] dvd [3];
  logic [22:0] tt [3];

  always_comb begin
    if (cfg.image_width == 7'd0) begin
      wm1 = 6'd0;
    end else if (cfg.image_width > 7'd64) begin
      wm1 = 6'd63;
    end else begin
      wm1 = 6'(cfg.image_width - 7'd1);
    end
    if (cfg.image_height == 7'd0) begin
      hm1 = 6'd0;
    end else if (cfg.image_height > 7'd64) begin
      hm1 = 6'd63;
    end else begin
      hm1 = 6'(cfg.image_height - 7'd1);
    end
    half = cfg.kernel_half;
    cc4  = (cfg.channel_count >= 3'd4);
    if (cfg.channel_count == 3'd0) begin
      nch = 2'd1;
    end else if (cfg.channel_count >= 3'd3) begin
      nch = 2'd3;
    end else begin
      nch = cfg.channel_count[1:0];
    end
  end

  always_comb begin
    sx = $signed({3'b000, cx_r}) + $signed({6'b0, cmd.ox}) - $signed({7'b0, half});
    sy = $signed({3'b000, cy_r}) + $signed({6'b0, cmd.oy}) - $signed({7'b0, half});
    if (sx < 0) begin
      nx = 6'd0;
    end else if (sx > $signed({3'b000, wm1})) begin
      nx = wm1;
    end else begin
      nx = sx[5:0];
    end
    if (sy < 0) begin
      ny = 6'd0;
    end else if (sy > $signed({3'b000, hm1})) begin
      ny = hm1;
    end else begin
      ny = sy[5:0];
    end
    adx   = (cmd.ox >= {1'b0, half}) ? cmd.ox - {1'b0, half} : {1'b0, half} - cmd.ox;
    ady   = (cmd.oy >= {1'b0, half}) ? cmd.oy - {1'b0, half} : {1'b0, half} - cmd.oy;
    dist2 = 5'(adx * adx) + 5'(ady * ady);
    rd_addr = cmd.rd_center ? {cy_r, cx_r} : {ny, nx};
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[{in_item.pixel_y, in_item.pixel_x}] <=
        {in_item.in_ch3, in_item.in_ch2, in_item.in_ch1, in_item.in_ch0};
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      x_r  <= in_item.pixel_x;
      y_r  <= in_item.pixel_y;
      cx_r <= (in_item.pixel_x > wm1) ? wm1 : in_item.pixel_x;
      cy_r <= (in_item.pixel_y > hm1) ? hm1 : in_item.pixel_y;
    end
    if (c1_r) begin
      center_r <= rdata_r;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dd[c] = (center_r[16*c +: 16] > rdata_r[16*c +: 16]) ?
              center_r[16*c +: 16] - rdata_r[16*c +: 16] :
              rdata_r[16*c +: 16] - center_r[16*c +: 16];
    end
    dsum = {2'b0, sq2_r[0]} + ((nch >= 2'd2) ? {2'b0, sq2_r[1]} : 34'd0)
         + ((nch == 2'd3) ? {2'b0, sq2_r[2]} : 34'd0);
    nn   = {p3_r[43:0], 8'b0};
    aa   = nn[51:32];
    ac   = {aa, 17'b0} - {17'b0, aa};
    s4   = {1'b0, nn} + {16'b0, ac};
    q1fs = {q14_r, 32'b0} - {15'b0, q14_r, 17'b0} + {32'b0, q14_r};
    r5   = {1'b0, n4_r} - q1fs;
    arg  = {1'b0, sp5_r, 8'b0} + {9'b0, q5_r};
    hi   = bif_pkg::EXP_ROM[{1'b0, idx6_r}];
    lo   = bif_pkg::EXP_ROM[{1'b0, idx6_r} + 9'd1];
    diff = (hi >= lo) ? hi - lo : 17'd0;
    rnd  = {1'b0, prod7_r} + 30'd2048;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; c1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_nb; c1_r <= cmd.rd_center; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r; v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    d2_1_r <= dist2;
    for (int c = 0; c < 3; c++) begin
      sq2_r[c]  <= dd[c] * dd[c];
      val2_r[c] <= rdata_r[16*c +: 16];
      val3_r[c] <= val2_r[c];
      val4_r[c] <= val3_r[c];
      val5_r[c] <= val4_r[c];
      val6_r[c] <= val5_r[c];
      val7_r[c] <= val6_r[c];
      val8_r[c] <= val7_r[c];
      wv9_r[c]  <= w8_r * val8_r[c];
    end
    sp2_r   <= d2_1_r * cfg.space_coeff;
    sp3_r   <= sp2_r;
    p3_r    <= dsum * cfg.color_coeff;
    sp4_r   <= sp3_r;
    big4_r  <= (p3_r >= bif_pkg::BIG_LIM);
    n4_r    <= nn;
    q14_r   <= s4[52:32];
    sp5_r   <= sp4_r;
    big5_r  <= big4_r;
    q5_r    <= q14_r + ((r5 >= bif_pkg::FS2) ? 21'd1 : 21'd0);
    zero6_r <= big5_r || (arg[29:20] != 10'd0);
    idx6_r  <= arg[19:12];
    frac6_r <= arg[11:0];
    prod7_r <= diff * frac6_r;
    hi7_r   <= hi;
    zero7_r <= zero6_r;
    w8_r    <= zero7_r ? 17'd0 : hi7_r - rnd[28:12];
    w9_r    <= w8_r;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dvd[c] = {1'b0, acc_r[c]} + {19'b0, sum_w_r[21:1]};
      tt[c]  = {rem_r[c], low_r[c][15]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      sum_w_r <= '0;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
    end else if (v9_r) begin
      sum_w_r <= sum_w_r + {5'b0, w9_r};
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_r[c] + {6'b0, wv9_r[c]};
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (cmd.div_init) begin
        rem_r[c] <= dvd[c][37:16];
        low_r[c] <= dvd[c][15:0];
      end else if (cmd.div_step) begin
        if (tt[c] >= {1'b0, sum_w_r}) begin
          rem_r[c] <= 22'(tt[c] - {1'b0, sum_w_r});
          low_r[c] <= {low_r[c][14:0], 1'b1};
        end else begin
          rem_r[c] <= tt[c][21:0];
          low_r[c] <= {low_r[c][14:0], 1'b0};
        end
      end
    end
    if (cmd.out_load) begin
      out_item.out_x   <= x_r;
      out_item.out_y   <= y_r;
      out_item.out_ch0 <= (sum_w_r != 22'd0) ? low_r[0] : 16'd0;
      out_item.out_ch1 <= (sum_w_r != 22'd0 && nch >= 2'd2) ? low_r[1] : 16'd0;
      out_item.out_ch2 <= (sum_w_r != 22'd0 && nch == 2'd3) ? low_r[2] : 16'd0;
      out_item.out_ch3 <= cc4 ? center_r[63:48] : 16'd0;
    end
  end

  assign status.pipe_busy = v1_r | v2_r | v3_r | v4_r | v5_r | v6_r | v7_r | v8_r | v9_r;

endmodule
